// File: src/apfbe_pkg.sv
// Package for the biphase-mark power frame encoder.
// Holds field widths, frame slot constants, power-code scaling constants and
// the control type of the frame-word cells. Depends on nothing.
package apfbe_pkg;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int SLOT_W   = 6;
    localparam int CODE_W   = 8;
    localparam int WORD_W   = CODE_W + 2;

    // Slot schedule of the 40-slot frame.
    localparam logic [SLOT_W-1:0] SLOT_START   = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_HOLD    = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_DATA_LO = SLOT_W'(3);
    localparam logic [SLOT_W-1:0] SLOT_DATA_HI = SLOT_W'(21);
    localparam logic [SLOT_W-1:0] SLOT_STOP_A  = SLOT_W'(22);
    localparam logic [SLOT_W-1:0] SLOT_STOP_B  = SLOT_W'(23);
    localparam logic [SLOT_W-1:0] SLOT_LAST    = SLOT_W'(39);

    // Power code = floor(p * 17 / 160), saturating at 255.
    // Samples at or above this value give a code of 255 or more.
    localparam logic [SAMPLE_W-1:0] SAMPLE_SAT = SAMPLE_W'(2410);
    localparam int SCALE_MUL = 17;
    localparam int PRE_SHIFT = 5;      // divide by 32 first
    localparam int RECIP5    = 52429;  // then by 5 via reciprocal
    localparam int RECIP_SH  = 18;
    localparam logic [CODE_W-1:0] CODE_MAX = '1;

    // Controls shared by every frame-word cell.
    typedef struct packed {
        logic load;   // latch a new word in slot 0
        logic shift;  // move toward cell 0 after a data bit is sent
    } t_cell_ctl;

endpackage

// File: src/apfbe_if.sv
// Valid/ready channel interfaces of the power frame encoder.
// Depends on apfbe_pkg for the field widths.
interface apfbe_in_if;
    import apfbe_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       enable;
    logic signed [SAMPLE_W-1:0] power_sample;
    logic                       request_bit;

    modport source (output valid, enable, power_sample, request_bit, input ready);
    modport sink   (input valid, enable, power_sample, request_bit, output ready);
endinterface

interface apfbe_out_if;
    import apfbe_pkg::*;

    logic              valid;
    logic              ready;
    logic              line_level;
    logic [SLOT_W-1:0] slot_number;
    logic [CODE_W-1:0] power_code;

    modport source (output valid, line_level, slot_number, power_code, input ready);
    modport sink   (input valid, line_level, slot_number, power_code, output ready);
endinterface

// File: src/apfbe_cell.sv
// One cell of the frame-word shift chain: holds one bit of the word.
// Depends on apfbe_pkg for the shared cell control type.
module apfbe_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  apfbe_pkg::t_cell_ctl  i_ctl,
    input  logic                  i_load_bit,
    input  logic                  i_next_bit,
    output logic                  o_bit
);
    import apfbe_pkg::*;

    logic r_bit;

    // Load the word bit in slot 0, otherwise take the neighbor's bit on a shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_ctl.load) begin
            r_bit <= i_load_bit;
        end else if (i_ctl.shift) begin
            r_bit <= i_next_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

// File: src/ask_power_frame_biphase_encoder_top.sv
// Top level of the biphase-mark power frame encoder.
// Depends on apfbe_pkg, the channel interfaces in apfbe_if and apfbe_cell.
//
//  Channel  | Dir | Payload                                   | Handshake
//  ---------+-----+-------------------------------------------+-----------
//  i_in     | in  | enable, power_sample, request_bit (tick)  | valid/ready
//  o_out    | out | line_level, slot_number, power_code       | valid/ready
//
// One item is taken per cycle while ready is high; results are registered.
// All frame state updates in the cycle of the accept; the power code is a
// constant multiply by 17, a shift and a reciprocal multiply by 5.
// A two-entry output stage (output register plus skid register) lets one more
// item in while a result waits; ready falls only when both entries are full.
// Reset is synchronous and active low; the line resets high, the slot to 0.
module ask_power_frame_biphase_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    apfbe_in_if.sink    i_in,
    apfbe_out_if.source o_out
);
    import apfbe_pkg::*;

    typedef struct packed {
        logic              line_level;
        logic [SLOT_W-1:0] slot_number;
        logic [CODE_W-1:0] power_code;
    } t_result;

    // Frame state.
    logic              r_level, n_level;
    logic [SLOT_W-1:0] r_slot,  n_slot;
    logic [CODE_W-1:0] r_code,  n_code;

    // Output register and skid register.
    t_result r_out,  r_skid;
    logic    r_out_valid, r_skid_valid;
    t_result n_result;

    logic w_accept;
    logic w_pop;

    // Power code datapath.
    logic [SAMPLE_W-1:0]           w_raw;
    logic [16:0]                   w_scaled;
    logic [16-PRE_SHIFT-1:0]       w_div32;
    logic [16-PRE_SHIFT+16-1:0]    w_recip;
    logic [CODE_W-1:0]             w_new_code;
    logic [WORD_W-1:0]             w_new_word;

    // Frame-word chain.
    t_cell_ctl         w_ctl;
    logic [WORD_W-1:0] w_word;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_pop    = o_out.valid && o_out.ready;
    assign i_in.ready = !r_skid_valid;

    // Power code: zero for non-positive samples, 255 at or above the limit,
    // otherwise floor(floor(p * 17 / 32) / 5).
    assign w_raw    = SAMPLE_W'(i_in.power_sample);
    assign w_scaled = 17'(w_raw[11:0]) * 17'(SCALE_MUL);
    assign w_div32  = w_scaled[16-1:PRE_SHIFT];
    assign w_recip  = (16-PRE_SHIFT+16)'(w_div32) * (16-PRE_SHIFT+16)'(RECIP5);

    always_comb begin
        priority if (w_raw[SAMPLE_W-1]) begin
            w_new_code = '0;
        end else if (w_raw >= SAMPLE_SAT) begin
            w_new_code = CODE_MAX;
        end else begin
            w_new_code = w_recip[RECIP_SH +: CODE_W];
        end
    end

    // New frame word: request bit, code, then even parity on top.
    assign w_new_word = {^{w_new_code, i_in.request_bit}, w_new_code, i_in.request_bit};

    // Slot schedule and line level for the accepted tick.
    always_comb begin
        n_level  = r_level;
        n_slot   = r_slot;
        n_code   = r_code;
        w_ctl    = '0;
        n_result = '0;
        n_result.slot_number = r_slot;
        priority if (!i_in.enable) begin
            n_level = 1'b0;
            n_slot  = '0;
            n_result.slot_number = '0;
        end else if (r_slot == SLOT_START) begin
            n_level    = 1'b1;
            n_code     = w_new_code;
            w_ctl.load = w_accept;
            n_slot     = SLOT_HOLD;
        end else if (r_slot == SLOT_HOLD || r_slot == SLOT_STOP_B) begin
            n_slot = r_slot + SLOT_W'(1);
        end else if (r_slot == SLOT_STOP_A) begin
            n_level = 1'b0;
            n_slot  = r_slot + SLOT_W'(1);
        end else if (r_slot >= SLOT_LAST) begin
            n_level = 1'b0;
            n_slot  = '0;
        end else if (!r_slot[0] || r_slot > SLOT_STOP_B) begin
            // Clock toggle on even slots and the whole trailer.
            n_level = !r_level;
            n_slot  = r_slot + SLOT_W'(1);
        end else begin
            // Odd data slot: toggle for a one, then advance the chain.
            n_level     = r_level ^ w_word[0];
            w_ctl.shift = w_accept;
            n_slot      = r_slot + SLOT_W'(1);
        end
        n_result.line_level = n_level;
        n_result.power_code = n_code;
    end

    // Row of frame-word cells, cell 0 feeding the data slots.
    for (genvar g = 0; g < WORD_W; g++) begin : g_cell
        logic w_next;
        if (g == WORD_W - 1) begin : g_end
            assign w_next = 1'b0;
        end else begin : g_mid
            assign w_next = w_word[g+1];
        end
        apfbe_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_load_bit (w_new_word[g]),
            .i_next_bit (w_next),
            .o_bit      (w_word[g])
        );
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b1;
            r_slot  <= '0;
            r_code  <= '0;
        end else if (w_accept) begin
            r_level <= n_level;
            r_slot  <= n_slot;
            r_code  <= n_code;
        end
    end

    // Output stage: a new result goes to the output register when it is free
    // or being taken, otherwise to the skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_accept) begin
            if (!r_out_valid || w_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (!r_out_valid || w_pop) begin
                r_out <= n_result;
            end else begin
                r_skid <= n_result;
            end
        end else if (w_pop && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.line_level  = r_out.line_level;
    assign o_out.slot_number = r_out.slot_number;
    assign o_out.power_code  = r_out.power_code;

endmodule

// File: src/apfbe_checker.sv
// Port-level checks of the power frame encoder, bound to its top level.
// Depends on apfbe_pkg and on the top level's interface ports.
module apfbe_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic                      i_out_level,
    input logic [apfbe_pkg::SLOT_W-1:0] i_out_slot,
    input logic [apfbe_pkg::CODE_W-1:0] i_out_code
);
    import apfbe_pkg::*;

    // A result never names a slot beyond the end of the frame.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_slot <= SLOT_LAST)
        else $error("slot number beyond frame end");

    // The stop slots always drive the line low.
    a_stop_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_slot == SLOT_STOP_A || i_out_slot == SLOT_STOP_B))
        |-> !i_out_level)
        else $error("line not low in a stop slot");

    // The second start slot keeps the line high.
    a_start_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_slot == SLOT_HOLD) |-> i_out_level)
        else $error("line not high in the second start slot");

    // Input back-pressure only while a result is waiting.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result pending");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_level) && $stable(i_out_slot) && $stable(i_out_code)))
        else $error("stalled result changed");

endmodule

bind ask_power_frame_biphase_encoder_top apfbe_checker u_apfbe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_level (o_out.line_level),
    .i_out_slot  (o_out.slot_number),
    .i_out_code  (o_out.power_code)
);

// File: verif/tb_ask_power_frame_biphase_encoder_top.sv
// Self-checking testbench for the biphase-mark power frame encoder top level.
// Needs apfbe_pkg, the channel interfaces in apfbe_if and the encoder RTL.
// A clocked driver feeds tick items from a queue; a clocked monitor checks every result.
`timescale 1ns / 1ps

module tb_ask_power_frame_biphase_encoder_top;
    import apfbe_pkg::*;

    // One tick item as queued for the driver.
    typedef struct {
        logic                       enable;
        logic signed [SAMPLE_W-1:0] power_sample;
        logic                       request_bit;
        logic                       hold_off;  // wait for every result before sending
    } t_tick_item;

    // One result as the encoder should deliver it.
    typedef struct {
        logic              line_level;
        logic [SLOT_W-1:0] slot_number;
        logic [CODE_W-1:0] power_code;
    } t_line_result;

    logic i_clk;
    logic i_rst_n;

    apfbe_in_if  in_ch ();
    apfbe_out_if out_ch ();

    ask_power_frame_biphase_encoder_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_tick_item   pending_ticks[$];
    t_line_result expected_line[$];
    t_tick_item   cur_tick;
    int unsigned  cycle_count;
    int unsigned  error_count;
    logic         calm;

    // Shadow copy of the encoder state.
    logic [SLOT_W-1:0] slot_q;
    logic [WORD_W-1:0] word_q;
    logic              level_q;
    logic [CODE_W-1:0] code_q;

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Advances the shadow state by one tick and returns the line result it gives.
    function automatic t_line_result encode_tick(t_tick_item t);
        t_line_result      r;
        logic [SLOT_W-1:0] s;
        logic [15:0]       raw;
        int unsigned       q;
        int                bit_idx;
        logic              flip;
        s = slot_q;
        r.slot_number = s;
        if (!t.enable) begin
            level_q = 1'b0;
            slot_q = '0;
            r.slot_number = '0;
        end else if (s == SLOT_START) begin
            // Latch the power code; zero and negative samples give code 0.
            raw = t.power_sample;
            if (raw == 16'd0 || raw[15]) begin
                q = 0;
            end else begin
                q = (int'(raw) * 255) / 2400;
                if (q > 255) q = 255;
            end
            level_q = 1'b1;
            code_q = q[CODE_W-1:0];
            word_q = {^{code_q, t.request_bit}, code_q, t.request_bit};
            slot_q = SLOT_HOLD;
        end else if (s == SLOT_HOLD || s == SLOT_STOP_B) begin
            slot_q = s + 1'b1;
        end else if (s == SLOT_STOP_A) begin
            level_q = 1'b0;
            slot_q = s + 1'b1;
        end else if (s >= SLOT_LAST) begin
            level_q = 1'b0;
            slot_q = '0;
        end else begin
            // Even slots and the trailer always toggle, odd data slots toggle for a one.
            if (!s[0] || s > SLOT_STOP_B) begin
                flip = 1'b1;
            end else begin
                bit_idx = int'(s >> 1) - 1;
                flip = word_q[bit_idx];
            end
            if (flip) level_q = ~level_q;
            slot_q = s + 1'b1;
        end
        r.line_level = level_q;
        r.power_code = code_q;
        return r;
    endfunction

    task automatic add_tick(input logic en, input logic signed [SAMPLE_W-1:0] p,
                            input logic req, input logic hold);
        t_tick_item t;
        t.enable = en;
        t.power_sample = p;
        t.request_bit = req;
        t.hold_off = hold;
        pending_ticks.push_back(t);
    endtask

    // Picks a power sample, biased toward zero, the saturation edge and small codes.
    function automatic logic signed [SAMPLE_W-1:0] pick_power();
        case ($urandom_range(4))
            0: return SAMPLE_W'($urandom());
            1: return SAMPLE_W'($urandom_range(2400));
            2: return SAMPLE_W'($urandom_range(2420, 2390));
            3: return -$signed(SAMPLE_W'($urandom_range(40)));
            default: return SAMPLE_W'($urandom_range(40));
        endcase
    endfunction

    // Queues one frame; ticks after the start carry random, ignored payload.
    // A length below 40 cuts the frame short with a disabled tick.
    task automatic add_frame(input int unsigned len, input logic hold);
        add_tick(1'b1, pick_power(), 1'($urandom_range(1)), hold);
        for (int unsigned i = 1; i < len; i++) begin
            add_tick(1'b1, SAMPLE_W'($urandom()), 1'($urandom_range(1)), 1'b0);
        end
        if (len < 40) add_tick(1'b0, SAMPLE_W'($urandom()), 1'($urandom_range(1)), 1'b0);
    endtask

    // Driver: predicts each accepted item and presents the next one.
    always @(posedge i_clk) begin
        logic fired;
        logic idle;
        cycle_count <= cycle_count + 1;
        calm <= (cycle_count >= 1000 && cycle_count < 2000);
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            fired = in_ch.valid && in_ch.ready;
            if (fired) expected_line.push_back(encode_tick(cur_tick));
            if (!in_ch.valid || fired) begin
                idle = !calm && ($urandom_range(99) < 21);
                if (pending_ticks.size() != 0 && !idle &&
                    !(pending_ticks[0].hold_off && expected_line.size() != 0)) begin
                    cur_tick = pending_ticks.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.enable <= cur_tick.enable;
                    in_ch.power_sample <= cur_tick.power_sample;
                    in_ch.request_bit <= cur_tick.request_bit;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and a field-by-field check of each result.
    always @(posedge i_clk) begin
        t_line_result want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_line.size() == 0) begin
                    $error("unexpected result: slot_number %0d", out_ch.slot_number);
                    error_count++;
                end else begin
                    want = expected_line.pop_front();
                    if (out_ch.line_level !== want.line_level) begin
                        $error("line_level: expected %0d, got %0d",
                               want.line_level, out_ch.line_level);
                        error_count++;
                    end
                    if (out_ch.slot_number !== want.slot_number) begin
                        $error("slot_number: expected %0d, got %0d",
                               want.slot_number, out_ch.slot_number);
                        error_count++;
                    end
                    if (out_ch.power_code !== want.power_code) begin
                        $error("power_code: expected %0d, got %0d",
                               want.power_code, out_ch.power_code);
                        error_count++;
                    end
                end
            end
        end
        out_ch.ready <= calm || ($urandom_range(99) >= 21);
    end

    // Stimulus, reset and the end of the run.
    initial begin
        int unsigned pick;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.enable = 1'b0;
        in_ch.power_sample = '0;
        in_ch.request_bit = 1'b0;
        out_ch.ready = 1'b0;
        cycle_count = 0;
        error_count = 0;
        calm = 1'b0;
        slot_q = '0;
        word_q = '0;
        level_q = 1'b1;
        code_q = '0;

        // Frame starts at the edges of the power range, each ended by a disabled tick.
        add_tick(1'b1, 16'sd0, 1'b0, 1'b0);
        add_tick(1'b1, 16'sd1, 1'b1, 1'b0);
        add_tick(1'b0, 16'sd0, 1'b0, 1'b0);
        add_tick(1'b1, -16'sd1, 1'b1, 1'b0);
        add_tick(1'b0, 16'sd0, 1'b0, 1'b0);
        add_tick(1'b1, -16'sd32768, 1'b0, 1'b0);
        add_tick(1'b0, -16'sd1, 1'b1, 1'b0);
        add_tick(1'b1, 16'sd32767, 1'b1, 1'b0);
        add_tick(1'b0, 16'sd32767, 1'b1, 1'b0);
        add_tick(1'b1, 16'sd2400, 1'b0, 1'b0);
        add_tick(1'b0, 16'sd0, 1'b0, 1'b0);
        add_tick(1'b1, 16'sd2409, 1'b1, 1'b0);
        add_tick(1'b0, 16'sd0, 1'b0, 1'b0);
        add_tick(1'b1, 16'sd2410, 1'b0, 1'b0);
        add_tick(1'b0, 16'sd0, 1'b0, 1'b0);
        add_tick(1'b1, 16'sd16, 1'b1, 1'b0);
        add_tick(1'b1, 16'sd0, 1'b0, 1'b0);
        add_tick(1'b0, 16'sd0, 1'b0, 1'b0);
        add_tick(1'b0, 16'sd0, 1'b0, 1'b0);

        // Random part: mostly whole frames, some cut short, some loose ticks.
        add_frame(40, 1'b1);
        while (pending_ticks.size() < 1530) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                add_frame(40, $urandom_range(39) == 0);
            end else if (pick < 90) begin
                add_frame($urandom_range(39, 1), 1'b0);
            end else begin
                repeat ($urandom_range(5, 1))
                    add_tick(1'($urandom_range(1)), SAMPLE_W'($urandom()),
                             1'($urandom_range(1)), 1'b0);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ticks.size() != 0 || in_ch.valid || expected_line.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (expected_line.size() != 0) begin
            $error("%0d expected results never arrived", expected_line.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
src/apfbe_pkg.sv
src/apfbe_if.sv
src/apfbe_cell.sv
src/ask_power_frame_biphase_encoder_top.sv
src/apfbe_checker.sv
verif/tb_ask_power_frame_biphase_encoder_top.sv
